@@ hdl/neighbor_table_aging_defines.svh @@
// Assertion macros for the neighbor table aging RTL, used by nta_dp.
`ifndef NEIGHBOR_TABLE_AGING_DEFINES_SVH
`define NEIGHBOR_TABLE_AGING_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define NTA_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define NTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/nta_pkg.sv @@
// Shared types and constants for the neighbor table aging block.
package nta_pkg;

    localparam logic [1:0] ST_REFRESHED = 2'd0;
    localparam logic [1:0] ST_ADDED     = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;
    localparam logic [1:0] ST_TICK      = 2'd3;

    localparam logic REQ_HELLO = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_full;
    } dp_stat_t;

endpackage

@@ hdl/nta_ctrl.sv @@
// Sequencer that steps one item through table walk and commit.
module nta_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nta_pkg::dp_stat_t stat,
    output nta_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!stat.out_full)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/nta_dp.sv @@
// Neighbor table storage, walk pointer, aging and result register.
`include "neighbor_table_aging_defines.svh"

module nta_dp
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int PORT_COUNT    = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  nta_pkg::dp_cmd_t  cmd,
    output nta_pkg::dp_stat_t stat,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              req_type,
    input  logic [1:0]        iface_num,
    input  logic [31:0]       peer_id,
    input  logic [31:0]       source_ip,
    input  logic [31:0]       net_mask,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [1:0]        status,
    output logic              lsu_needed,
    output logic [4:0]        removed_count,
    output logic [4:0]        neighbor_count
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] WALK_END = CNT_W'(TABLE_ENTRIES);

    logic [31:0] router_mem [TABLE_ENTRIES];
    logic [31:0] addr_mem   [TABLE_ENTRIES];
    logic [31:0] mask_mem   [TABLE_ENTRIES];
    logic [1:0]  port_mem   [TABLE_ENTRIES];
    logic [15:0] age_mem    [TABLE_ENTRIES];

    logic [15:0]              dead_limit_reg, dead_limit_next;
    logic                     req_tick_reg;
    logic [1:0]               req_port_reg;
    logic [31:0]              req_router_reg;
    logic [31:0]              req_addr_reg;
    logic [31:0]              req_mask_reg;
    logic [CNT_W-1:0]         walk_reg, walk_next;
    logic                     proc_en_reg, proc_en_next;
    logic [IDX_W-1:0]         proc_idx_reg;
    logic                     hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic                     slot_found_reg, slot_found_next;
    logic [IDX_W-1:0]         slot_idx_reg;
    logic [CNT_W-1:0]         removed_reg, removed_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic                     out_lsu_reg, out_lsu_next;
    logic [4:0]               out_removed_reg, out_removed_next;
    logic [4:0]               out_count_reg, out_count_next;
    logic [31:0]              rd_router_reg;
    logic [1:0]               rd_port_reg;
    logic [15:0]              rd_age_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             entry_live;
    logic             entry_free;
    logic             age_expired;
    logic             port_bad;
    logic             tick_remove;
    logic             tick_bump;
    logic             hello_match;
    logic             hello_free;
    logic             commit_add;
    logic             commit_refresh;
    logic             age_we;
    logic [IDX_W-1:0] age_widx;
    logic [15:0]      age_wdata;

    assign rd_en  = cmd.scan && (walk_reg != WALK_END);
    assign rd_idx = walk_reg[IDX_W-1:0];

    assign entry_live  = proc_en_reg && valid_reg[proc_idx_reg];
    assign entry_free  = proc_en_reg && !valid_reg[proc_idx_reg];
    assign age_expired = (rd_age_reg >= dead_limit_reg);
    assign port_bad    = ({30'd0, req_port_reg} >= 32'(PORT_COUNT));

    assign tick_remove = cmd.scan && (req_tick_reg == nta_pkg::REQ_TICK) && entry_live
                         && age_expired;
    assign tick_bump   = cmd.scan && (req_tick_reg == nta_pkg::REQ_TICK) && entry_live
                         && !age_expired;
    assign hello_match = cmd.scan && (req_tick_reg == nta_pkg::REQ_HELLO) && entry_live
                         && !hit_found_reg && (rd_port_reg == req_port_reg)
                         && (rd_router_reg == req_router_reg);
    assign hello_free  = cmd.scan && (req_tick_reg == nta_pkg::REQ_HELLO) && entry_free
                         && !slot_found_reg;

    assign commit_refresh = cmd.commit && (req_tick_reg == nta_pkg::REQ_HELLO) && !port_bad
                            && hit_found_reg;
    assign commit_add     = cmd.commit && (req_tick_reg == nta_pkg::REQ_HELLO) && !port_bad
                            && !hit_found_reg && slot_found_reg;

    assign age_we    = tick_bump || commit_refresh || commit_add;
    assign age_widx  = tick_bump ? proc_idx_reg : (hit_found_reg ? hit_idx_reg : slot_idx_reg);
    assign age_wdata = tick_bump ? (rd_age_reg + 16'd1) : 16'd0;

    assign stat.walk_done = (walk_reg == WALK_END) && !proc_en_reg;
    assign stat.out_full  = out_valid_reg && !out_ready;

    always_comb
    begin
        dead_limit_next  = cfg_we ? cfg_wdata : dead_limit_reg;
        walk_next        = walk_reg;
        proc_en_next     = 1'b0;
        hit_found_next   = hit_found_reg;
        slot_found_next  = slot_found_reg;
        removed_next     = removed_reg;
        count_next       = count_reg;
        valid_next       = valid_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_lsu_next     = out_lsu_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;

        if (cmd.start)
        begin
            walk_next       = '0;
            hit_found_next  = 1'b0;
            slot_found_next = 1'b0;
            removed_next    = '0;
        end

        if (rd_en)
        begin
            walk_next    = walk_reg + CNT_W'(1);
            proc_en_next = 1'b1;
        end

        if (hello_match)
        begin
            hit_found_next = 1'b1;
        end
        if (hello_free)
        begin
            slot_found_next = 1'b1;
        end

        if (tick_remove)
        begin
            valid_next[proc_idx_reg] = 1'b0;
            removed_next             = removed_reg + CNT_W'(1);
            count_next               = count_reg - CNT_W'(1);
        end

        if (commit_add)
        begin
            valid_next[slot_idx_reg] = 1'b1;
            count_next               = count_reg + CNT_W'(1);
        end

        if (cmd.commit)
        begin
            out_valid_next   = 1'b1;
            out_removed_next = 5'(removed_reg);
            out_count_next   = 5'(count_next);
            out_lsu_next     = 1'b0;
            if (req_tick_reg == nta_pkg::REQ_TICK)
            begin
                out_status_next = nta_pkg::ST_TICK;
                out_lsu_next    = (removed_reg != '0);
            end
            else if (port_bad)
            begin
                out_status_next = nta_pkg::ST_REJECTED;
            end
            else if (hit_found_reg)
            begin
                out_status_next = nta_pkg::ST_REFRESHED;
            end
            else if (slot_found_reg)
            begin
                out_status_next = nta_pkg::ST_ADDED;
                out_lsu_next    = 1'b1;
            end
            else
            begin
                out_status_next = nta_pkg::ST_REJECTED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_limit_reg <= 16'd15;
            walk_reg       <= '0;
            proc_en_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            slot_found_reg <= 1'b0;
            removed_reg    <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            dead_limit_reg <= dead_limit_next;
            walk_reg       <= walk_next;
            proc_en_reg    <= proc_en_next;
            hit_found_reg  <= hit_found_next;
            slot_found_reg <= slot_found_next;
            removed_reg    <= removed_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_tick_reg   <= req_type;
            req_port_reg   <= iface_num;
            req_router_reg <= peer_id;
            req_addr_reg   <= source_ip;
            req_mask_reg   <= net_mask;
        end
        if (rd_en)
        begin
            proc_idx_reg <= rd_idx;
        end
        if (hello_match)
        begin
            hit_idx_reg <= proc_idx_reg;
        end
        if (hello_free)
        begin
            slot_idx_reg <= proc_idx_reg;
        end
        out_status_reg  <= out_status_next;
        out_lsu_reg     <= out_lsu_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_router_reg <= router_mem[rd_idx];
            rd_port_reg   <= port_mem[rd_idx];
            rd_age_reg    <= age_mem[rd_idx];
        end
        if (commit_add)
        begin
            router_mem[slot_idx_reg] <= req_router_reg;
            addr_mem[slot_idx_reg]   <= req_addr_reg;
            mask_mem[slot_idx_reg]   <= req_mask_reg;
            port_mem[slot_idx_reg]   <= req_port_reg;
        end
        if (age_we)
        begin
            age_mem[age_widx] <= age_wdata;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign lsu_needed     = out_lsu_reg;
    assign removed_count  = out_removed_reg;
    assign neighbor_count = out_count_reg;

    `NTA_ASSERT_HOLDS(a_count_tracks_valid, 1'b1,
        count_reg == CNT_W'($countones(valid_reg)), "neighbor count out of step with valid bits")
    `NTA_ASSERT_HOLDS(a_commit_after_walk, cmd.commit,
        (walk_reg == WALK_END) && !proc_en_reg, "commit before the table walk finished")
    `NTA_ASSERT_HOLDS(a_add_into_free_slot, commit_add,
        !valid_reg[slot_idx_reg], "new neighbor stored over a valid entry")
    `NTA_ASSERT_HOLDS(a_commit_output_free, cmd.commit,
        !out_valid_reg || out_ready, "result overwritten before it was taken")
    `NTA_ASSERT_NEXT(a_commit_shows_result, cmd.commit,
        out_valid_reg, "commit did not present a result")

endmodule

@@ hdl/neighbor_table_aging.sv @@
// Neighbor table with hello refresh/insert and tick aging. An accepted item
// walks all TABLE_ENTRIES entries through the table memory's single read
// port, one entry per cycle, then commits. The result is held in the output
// register until taken, and the next item is accepted only after the
// commit, while the result may still wait in the output register.
// Only one commit waits on a full output register.
// dead_limit may be written only while no item is in flight.
module neighbor_table_aging
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int PORT_COUNT    = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [1:0]  iface_num,
    input  logic [31:0] peer_id,
    input  logic [31:0] source_ip,
    input  logic [31:0] net_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        lsu_needed,
    output logic [4:0]  removed_count,
    output logic [4:0]  neighbor_count
);

    nta_pkg::dp_cmd_t  cmd;
    nta_pkg::dp_stat_t stat;

    nta_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nta_dp
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_type       (req_type),
        .iface_num      (iface_num),
        .peer_id        (peer_id),
        .source_ip      (source_ip),
        .net_mask       (net_mask),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .lsu_needed     (lsu_needed),
        .removed_count  (removed_count),
        .neighbor_count (neighbor_count)
    );

endmodule

@@ verif/tb_neighbor_table_aging.sv @@
`timescale 1ns / 1ps
// Testbench for neighbor_table_aging: hello and tick items checked against a table predictor.
module tb_neighbor_table_aging;

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_PORTS   = 4;
    localparam int POOL_SIZE   = 20;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 112;

    typedef struct packed {
        logic [1:0] status;
        logic       lsu_needed;
        logic [4:0] removed_count;
        logic [4:0] neighbor_count;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [1:0]  iface_num;
    logic [31:0] peer_id;
    logic [31:0] source_ip;
    logic [31:0] net_mask;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        lsu_needed;
    logic [4:0]  removed_count;
    logic [4:0]  neighbor_count;

    logic [15:0] dead_limit_q;
    logic        nb_valid   [NUM_ENTRIES];
    logic [31:0] nb_router  [NUM_ENTRIES];
    logic [31:0] nb_address [NUM_ENTRIES];
    logic [31:0] nb_mask    [NUM_ENTRIES];
    logic [1:0]  nb_port    [NUM_ENTRIES];
    logic [15:0] nb_age     [NUM_ENTRIES];

    table_result_t expected_results[$];
    int            fail_count  = 0;
    bit            idle_enable = 1'b1;

    neighbor_table_aging
    #(
        .TABLE_ENTRIES (NUM_ENTRIES),
        .PORT_COUNT    (NUM_PORTS)
    )
    dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .iface_num      (iface_num),
        .peer_id        (peer_id),
        .source_ip      (source_ip),
        .net_mask       (net_mask),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .lsu_needed     (lsu_needed),
        .removed_count  (removed_count),
        .neighbor_count (neighbor_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic table_result_t table_update(input logic kind, input logic [1:0] ifc,
                                                   input logic [31:0] rid, input logic [31:0] sip,
                                                   input logic [31:0] msk);
        table_result_t r;
        int hit;
        int slot;
        int removed;
        int count;
        hit = -1;
        slot = -1;
        removed = 0;
        count = 0;
        r.lsu_needed = 1'b0;
        if (kind == nta_pkg::REQ_TICK)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (nb_valid[i])
                begin
                    if (nb_age[i] >= dead_limit_q)
                    begin
                        nb_valid[i] = 1'b0;
                        removed++;
                    end
                    else
                    begin
                        nb_age[i] = nb_age[i] + 16'd1;
                    end
                end
            end
            r.status = nta_pkg::ST_TICK;
            r.lsu_needed = (removed != 0);
        end
        else if (int'(ifc) >= NUM_PORTS)
        begin
            r.status = nta_pkg::ST_REJECTED;
        end
        else
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (nb_valid[i])
                begin
                    if (hit < 0 && nb_port[i] == ifc && nb_router[i] == rid)
                        hit = i;
                end
                else if (slot < 0)
                begin
                    slot = i;
                end
            end
            if (hit >= 0)
            begin
                nb_age[hit] = 16'd0;
                r.status = nta_pkg::ST_REFRESHED;
            end
            else if (slot >= 0)
            begin
                nb_valid[slot]   = 1'b1;
                nb_router[slot]  = rid;
                nb_address[slot] = sip;
                nb_mask[slot]    = msk;
                nb_port[slot]    = ifc;
                nb_age[slot]     = 16'd0;
                r.status = nta_pkg::ST_ADDED;
                r.lsu_needed = 1'b1;
            end
            else
            begin
                r.status = nta_pkg::ST_REJECTED;
            end
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (nb_valid[i])
                count++;
        end
        r.removed_count  = 5'(removed);
        r.neighbor_count = 5'(count);
        return r;
    endfunction

    task automatic send_item(input logic kind, input logic [1:0] ifc, input logic [31:0] rid,
                             input logic [31:0] sip, input logic [31:0] msk);
        int gap;
        gap = idle_enable ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        iface_num <= ifc;
        peer_id   <= rid;
        source_ip <= sip;
        net_mask  <= msk;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        expected_results.push_back(table_update(kind, ifc, rid, sip, msk));
    endtask

    task automatic hello(input logic [1:0] ifc, input logic [31:0] rid, input logic [31:0] sip,
                         input logic [31:0] msk);
        send_item(nta_pkg::REQ_HELLO, ifc, rid, sip, msk);
    endtask

    task automatic tick();
        send_item(nta_pkg::REQ_TICK, 2'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        dead_limit_q = value;
    endtask

    task automatic test_hello_basics();
        tick();
        hello(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        hello(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        hello(2'd0, 32'h0000_0000, $urandom, $urandom);
        hello(2'd3, 32'h0000_0000, $urandom, $urandom);
        hello(2'd1, 32'hFFFF_FFFF, $urandom, $urandom);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < 12; i++)
            hello(2'(i), 32'h0A00_0100 + i, $urandom, $urandom);
        hello(2'd2, 32'h5A5A_A5A5, $urandom, $urandom);
        hello(2'd3, 32'hFFFF_FFFF, $urandom, $urandom);
    endtask

    task automatic test_limit_extremes();
        write_limit(16'd0);
        tick();
        write_limit(16'd1);
        hello(2'd2, $urandom, $urandom, $urandom);
        tick();
        tick();
    endtask

    task automatic test_limit_lowered();
        write_limit(16'hFFFF);
        hello(2'd1, 32'h0101_0101, $urandom, $urandom);
        tick();
        tick();
        hello(2'd2, 32'h0202_0202, $urandom, $urandom);
        write_limit(16'd1);
        tick();
        tick();
    endtask

    task automatic test_random_traffic();
        logic [31:0] pool_rid [POOL_SIZE];
        logic [1:0]  pool_if  [POOL_SIZE];
        logic [15:0] phase_limit [PHASES] = '{16'd3, 16'd1, 16'd15, 16'hFFFF, 16'd2,
                                              16'd5, 16'd8, 16'd0, 16'd4, 16'd0};
        int pick;
        int k;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i % 2 == 1)
            begin
                pool_rid[i] = pool_rid[i - 1];
                pool_if[i]  = pool_if[i - 1] + 2'd1;
            end
            else
            begin
                pool_rid[i] = $urandom;
                pool_if[i]  = 2'($urandom);
            end
        end
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase_limit[phase] == 16'd0)
                write_limit(16'($urandom_range(1, 40)));
            else
                write_limit(phase_limit[phase]);
            idle_enable = (phase % 3 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                begin
                    tick();
                end
                else if (pick < 85)
                begin
                    k = $urandom_range(0, POOL_SIZE - 1);
                    hello(pool_if[k], pool_rid[k], $urandom, $urandom);
                end
                else
                begin
                    hello(2'($urandom), $urandom, $urandom, $urandom);
                end
            end
        end
        wait_idle();
        idle_enable = 1'b1;
    endtask

    initial
    begin : result_check
        table_result_t want;
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = idle_enable ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d, neighbor_count %0d", status, neighbor_count);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (lsu_needed !== want.lsu_needed)
                begin
                    $error("lsu_needed: expected %0d, actual %0d", want.lsu_needed, lsu_needed);
                    fail_count++;
                end
                if (removed_count !== want.removed_count)
                begin
                    $error("removed_count: expected %0d, actual %0d",
                           want.removed_count, removed_count);
                    fail_count++;
                end
                if (neighbor_count !== want.neighbor_count)
                begin
                    $error("neighbor_count: expected %0d, actual %0d",
                           want.neighbor_count, neighbor_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 16'd0;
        in_valid  = 1'b0;
        req_type  = nta_pkg::REQ_HELLO;
        iface_num = 2'd0;
        peer_id   = 32'd0;
        source_ip = 32'd0;
        net_mask  = 32'd0;
        dead_limit_q = 16'd15;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            nb_valid[i]   = 1'b0;
            nb_router[i]  = 32'd0;
            nb_address[i] = 32'd0;
            nb_mask[i]    = 32'd0;
            nb_port[i]    = 2'd0;
            nb_age[i]     = 16'd0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_hello_basics();
        test_table_full();
        test_limit_extremes();
        test_limit_lowered();
        test_random_traffic();

        wait_idle();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ neighbor_table_aging.f @@
+incdir+hdl
hdl/nta_pkg.sv
hdl/nta_ctrl.sv
hdl/nta_dp.sv
hdl/neighbor_table_aging.sv
verif/tb_neighbor_table_aging.sv
